### hdl/pst_pkg.sv
`default_nettype none
package pst_pkg;

    localparam int REQ_W  = 3;
    localparam int PRIO_W = 6;
    localparam int ID_W   = 4;
    localparam int ERR_W  = 2;

    localparam logic [REQ_W-1:0] REQ_START    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CREATE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RESCHED  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CSYNC    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WAIT     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SIGNAL   = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_SYNC = 2'd2;

    localparam logic [PRIO_W-1:0] START_PRIO  = 6'h30;

    typedef logic [ID_W-1:0] t_id;

    typedef struct packed {
        logic load;
        logic exec;
        logic apply;
        logic prep;
        logic scan;
        logic commit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sync_go;
        logic resched;
        logic scan_end;
    } t_dp_status;

endpackage
`default_nettype wire

### hdl/priority_thread_scheduler_top.sv
`default_nettype none
// Start, create, create-sync, an unknown request or a bad sync id pass from decode to done;
// reschedule adds the prep, scan and commit states, and wait and signal also an apply state.
// The scan reads one thread priority a cycle from the priority memory port.
// One request in flight; the next is taken once the result is posted and the controller is idle.
// Reset (synchronous, active low) clears thread and sync counts, the current
// thread and the cpu-wait flag at once; a waiter mask is cleared when allocated.
module priority_thread_scheduler_top
    import pst_pkg::*;
#(
    parameter int MAX_THREADS      = 16,
    parameter int MAX_SYNC_OBJECTS = 16
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // priority_req[5:0], sync_id[9:6]
    input  wire logic [2:0]  i_s_axis_tuser,  // req_type[2:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata   // ok[0], error_code[2:1], new_id[6:3],
                                              // current_thread[10:7], cpu_waiting[11]
);

    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic             w_ok;
    logic [ERR_W-1:0] w_err;
    logic [ID_W-1:0]  w_nid;
    logic [ID_W-1:0]  w_cur;
    logic             w_cpu_wait;

    pst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pst_datapath #(
        .MAX_THREADS      (MAX_THREADS),
        .MAX_SYNC_OBJECTS (MAX_SYNC_OBJECTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_req_type       (i_s_axis_tuser),
        .i_priority_req   (i_s_axis_tdata[5:0]),
        .i_sync_id        (i_s_axis_tdata[9:6]),
        .o_ok             (w_ok),
        .o_error_code     (w_err),
        .o_new_id         (w_nid),
        .o_current_thread (w_cur),
        .o_cpu_waiting    (w_cpu_wait)
    );

    assign o_m_axis_tdata = {4'b0000, w_cpu_wait, w_cur, w_nid, w_err, w_ok};

endmodule
`default_nettype wire

### hdl/pst_ctrl.sv
`default_nettype none
module pst_ctrl
    import pst_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_APPLY  = 7'b0000100,
        S_PREP   = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_COMMIT = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
                if (i_status.sync_go) begin
                    n_state = S_APPLY;
                end else if (i_status.resched) begin
                    n_state = S_PREP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_end) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

### hdl/pst_datapath.sv
`default_nettype none
module pst_datapath
    import pst_pkg::*;
#(
    parameter int MAX_THREADS      = 16,
    parameter int MAX_SYNC_OBJECTS = 16
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [PRIO_W-1:0] i_priority_req,
    input  wire logic [ID_W-1:0]   i_sync_id,
    output logic                   o_ok,
    output logic [ERR_W-1:0]       o_error_code,
    output logic [ID_W-1:0]        o_new_id,
    output logic [ID_W-1:0]        o_current_thread,
    output logic                   o_cpu_waiting
);

    localparam int TW  = $clog2(MAX_THREADS);
    localparam int TCW = $clog2(MAX_THREADS + 1);
    localparam int SW  = (MAX_SYNC_OBJECTS > 1) ? $clog2(MAX_SYNC_OBJECTS) : 1;
    localparam int SCW = $clog2(MAX_SYNC_OBJECTS + 1);
    localparam int CW  = (SCW > ID_W) ? SCW : ID_W;

    logic [PRIO_W-1:0]      mem_prio [MAX_THREADS];
    logic [MAX_THREADS-1:0] mem_mask [MAX_SYNC_OBJECTS];

    logic [REQ_W-1:0]       r_req;
    logic [PRIO_W-1:0]      r_prio;
    logic [ID_W-1:0]        r_sid;
    logic [TCW-1:0]         r_tcount;
    logic [SCW-1:0]         r_scount;
    logic [TW-1:0]          r_cur;
    logic                   r_cpu_wait;
    logic [MAX_THREADS-1:0] r_rdy;
    logic [MAX_THREADS-1:0] r_run;
    logic [MAX_THREADS-1:0] r_mask_rd;
    logic [PRIO_W-1:0]      r_prio_rd;
    logic [TCW-1:0]         r_idx;
    logic [TW-1:0]          r_vidx;
    logic                   r_vld;
    logic [TW-1:0]          r_best;
    logic [PRIO_W-1:0]      r_max;
    logic                   r_found;
    logic                   r_ok;
    logic [ERR_W-1:0]       r_err;
    logic [ID_W-1:0]        r_nid;

    logic                   w_tfull;
    logic                   w_sfull;
    logic                   w_sid_ok;
    logic                   w_is_thr;
    logic                   w_is_wait;
    logic                   w_is_sig;
    logic [TW-1:0]          w_tid;
    logic [SW-1:0]          w_saddr;
    logic                   w_mwe;
    logic [SW-1:0]          w_maddr;
    logic [MAX_THREADS-1:0] w_mdata;
    logic [MAX_THREADS-1:0] w_cur_bit;
    logic                   w_take;

    assign w_tfull   = (r_tcount == TCW'(MAX_THREADS));
    assign w_sfull   = (r_scount == SCW'(MAX_SYNC_OBJECTS));
    assign w_sid_ok  = (CW'(r_sid) < CW'(r_scount));
    assign w_is_thr  = (r_req == REQ_START) || (r_req == REQ_CREATE);
    assign w_is_wait = (r_req == REQ_WAIT);
    assign w_is_sig  = (r_req == REQ_SIGNAL);
    assign w_tid     = r_tcount[TW-1:0];
    assign w_saddr   = SW'(r_sid);
    assign w_cur_bit = {{(MAX_THREADS-1){1'b0}}, 1'b1} << r_cur;
    assign w_take    = r_vld && r_rdy[r_vidx] && (r_prio_rd >= r_max);

    assign o_status.sync_go  = (w_is_wait || w_is_sig) && w_sid_ok;
    assign o_status.resched  = (r_req == REQ_RESCHED);
    assign o_status.scan_end = (r_idx >= r_tcount);

    always_comb begin
        w_mwe   = 1'b0;
        w_maddr = w_saddr;
        w_mdata = '0;
        if (i_cmd.exec && (r_req == REQ_CSYNC) && !w_sfull) begin
            w_mwe   = 1'b1;
            w_maddr = SW'(r_scount);
        end else if (i_cmd.apply) begin
            w_mwe   = 1'b1;
            w_mdata = w_is_wait ? (r_mask_rd | w_cur_bit) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            mem_mask[w_maddr] <= w_mdata;
        end
        r_mask_rd <= mem_mask[w_saddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_is_thr && !w_tfull) begin
            mem_prio[w_tid] <= (r_req == REQ_START) ? START_PRIO : r_prio;
        end
        r_prio_rd <= mem_prio[r_idx[TW-1:0]];
        r_vidx    <= r_idx[TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_is_thr && !w_tfull) begin
            r_rdy[w_tid] <= (r_req != REQ_START);
            r_run[w_tid] <= (r_req == REQ_START);
        end else if (i_cmd.apply) begin
            if (w_is_wait) begin
                r_rdy[r_cur] <= 1'b0;
                r_run[r_cur] <= 1'b0;
            end else begin
                r_rdy <= r_rdy | r_mask_rd;
                r_run <= r_run & ~r_mask_rd;
            end
        end else if (i_cmd.prep) begin
            if (r_run[r_cur]) begin
                r_rdy[r_cur] <= 1'b1;
                r_run[r_cur] <= 1'b0;
            end
        end else if (i_cmd.commit && r_found) begin
            r_rdy[r_best] <= 1'b0;
            r_run[r_best] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_prio <= i_priority_req;
            r_sid  <= i_sync_id;
        end
        if (i_cmd.prep) begin
            r_found <= 1'b0;
            r_max   <= '0;
            r_best  <= '0;
        end else if (w_take) begin
            r_found <= 1'b1;
            r_max   <= r_prio_rd;
            r_best  <= r_vidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ok  <= 1'b0;
            r_err <= ERR_NONE;
            r_nid <= '0;
        end else if (i_cmd.exec) begin
            case (r_req)
                REQ_START, REQ_CREATE: begin
                    r_ok  <= !w_tfull;
                    r_err <= w_tfull ? ERR_FULL : ERR_NONE;
                    r_nid <= w_tfull ? t_id'(0) : t_id'(w_tid);
                end
                REQ_CSYNC: begin
                    r_ok  <= !w_sfull;
                    r_err <= w_sfull ? ERR_FULL : ERR_NONE;
                    r_nid <= w_sfull ? t_id'(0) : t_id'(r_scount);
                end
                REQ_WAIT, REQ_SIGNAL: begin
                    r_err <= w_sid_ok ? ERR_NONE : ERR_BAD_SYNC;
                end
                default: begin
                    r_ok <= 1'b0;
                end
            endcase
        end else if (i_cmd.commit) begin
            r_ok <= r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcount   <= '0;
            r_scount   <= '0;
            r_cur      <= '0;
            r_cpu_wait <= 1'b0;
            r_idx      <= '0;
            r_vld      <= 1'b0;
        end else begin
            r_vld <= i_cmd.scan && (r_idx < r_tcount);
            if (i_cmd.prep) begin
                r_idx <= '0;
            end else if (i_cmd.scan && (r_idx < r_tcount)) begin
                r_idx <= r_idx + TCW'(1);
            end
            if (i_cmd.exec && w_is_thr && !w_tfull) begin
                r_tcount <= r_tcount + TCW'(1);
                if (r_req == REQ_START) begin
                    r_cur <= w_tid;
                end
            end
            if (i_cmd.exec && (r_req == REQ_CSYNC) && !w_sfull) begin
                r_scount <= r_scount + SCW'(1);
            end
            if (i_cmd.commit) begin
                r_cpu_wait <= !r_found;
                if (r_found) begin
                    r_cur <= r_best;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_ok             <= r_ok;
            o_error_code     <= r_err;
            o_new_id         <= r_nid;
            o_current_thread <= t_id'(r_cur);
            o_cpu_waiting    <= r_cpu_wait;
        end
    end

endmodule
`default_nettype wire
